[rtl/pll_mnp_divider_search_defines.svh]
// Assertion macros for the PLL divider search block.
// No dependencies; included by files that carry assertions.
`ifndef PLL_MNP_DIVIDER_SEARCH_DEFINES_SVH
`define PLL_MNP_DIVIDER_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
`define PMDS_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pmds: assertion failed");
`define PMDS_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pmds: assertion failed");
`else
`define PMDS_ASSERT_IMPLY(name, clk, rst, pre, post)
`define PMDS_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

[rtl/pmds_pkg.sv]
// Package for the PLL divider search: widths, constants, reciprocal table
// and the microcode program. No dependencies.
package pmds_pkg;

   localparam int TGT_W   = 20;
   localparam int N_W     = 7;
   localparam int M_W     = 3;
   localparam int P_W     = 3;
   localparam int BAND_W  = 2;
   localparam int FREQ_W  = 21;
   localparam int ERR_W   = 21;
   localparam int REF_W   = 15;
   localparam int PROD_W  = 22;
   localparam int RECIP_W = 25;
   localparam int RECIP_SHIFT = 25;
   localparam int MUL_W   = PROD_W + RECIP_W;
   localparam int FVCO_W  = 23;
   localparam int VMAX_W  = 19;
   localparam int PIDX_W  = 2;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [REF_W-1:0]  REF_A_KHZ = 15'd14318;
   localparam logic [REF_W-1:0]  REF_B_KHZ = 15'd27000;
   localparam logic [ERR_W-1:0]  ERR_LIMIT = 21'd250000;
   localparam logic [FVCO_W-1:0] VCO_FLOOR = 23'd50000;
   localparam logic [FVCO_W-1:0] BAND_T1   = 23'd100000;
   localparam logic [FVCO_W-1:0] BAND_T2   = 23'd140000;
   localparam logic [FVCO_W-1:0] BAND_T3   = 23'd180000;
   localparam logic [VMAX_W-1:0] VCO_OFS   = 19'd100;
   localparam logic [VMAX_W-1:0] VCO_SCALE = 19'd1000;

   localparam logic [N_W-1:0]    N_MIN = 7'd7;
   localparam logic [M_W-1:0]    M_MIN = 3'd1;
   localparam logic [M_W-1:0]    M_MAX = 3'd6;
   localparam logic [PIDX_W-1:0] PIDX_LAST = 2'd3;

   // register indexes
   localparam logic [CSR_AW-3:0] REG_REF_SELECT = 1'd0;
   localparam logic [CSR_AW-3:0] REG_VCO_MAX    = 1'd1;
   localparam logic              REF_SEL_RST    = 1'b1;
   localparam logic [7:0]        VCO_MAX_RST    = 8'd130;

   // microcode
   localparam int STEP_W = 3;
   localparam int OP_W   = 3;
   localparam int COND_W = 3;

   localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_POST  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_ISSUE = 3'd2;
   localparam logic [STEP_W-1:0] STEP_NEXT  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_DRAIN = 3'd4;
   localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd5;

   localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
   localparam logic [OP_W-1:0] OP_ACCEPT = 3'd1;
   localparam logic [OP_W-1:0] OP_POST   = 3'd2;
   localparam logic [OP_W-1:0] OP_ISSUE  = 3'd3;
   localparam logic [OP_W-1:0] OP_NEXT   = 3'd4;
   localparam logic [OP_W-1:0] OP_EMIT   = 3'd5;

   localparam logic [COND_W-1:0] C_NEVER     = 3'd0;
   localparam logic [COND_W-1:0] C_REQ       = 3'd1;
   localparam logic [COND_W-1:0] C_SKIP      = 3'd2;
   localparam logic [COND_W-1:0] C_LAST      = 3'd3;
   localparam logic [COND_W-1:0] C_MORE_POST = 3'd4;
   localparam logic [COND_W-1:0] C_EMPTY     = 3'd5;
   localparam logic [COND_W-1:0] C_OUT_FREE  = 3'd6;
   localparam logic [COND_W-1:0] C_ALWAYS    = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic              hold;    // stay on this step while cond is false
      logic [STEP_W-1:0] target;  // jump target when cond is true
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] pc);
      ucode_type w;
      case (pc)
         STEP_IDLE: begin
            w = '{op: OP_ACCEPT, cond: C_REQ, hold: 1'b1, target: STEP_POST};
         end
         STEP_POST: begin
            w = '{op: OP_POST, cond: C_SKIP, hold: 1'b0, target: STEP_NEXT};
         end
         STEP_ISSUE: begin
            w = '{op: OP_ISSUE, cond: C_LAST, hold: 1'b1, target: STEP_NEXT};
         end
         STEP_NEXT: begin
            w = '{op: OP_NEXT, cond: C_MORE_POST, hold: 1'b0, target: STEP_POST};
         end
         STEP_DRAIN: begin
            w = '{op: OP_NOP, cond: C_EMPTY, hold: 1'b1, target: STEP_EMIT};
         end
         STEP_EMIT: begin
            w = '{op: OP_EMIT, cond: C_OUT_FREE, hold: 1'b1, target: STEP_IDLE};
         end
         default: begin
            w = '{op: OP_NOP, cond: C_ALWAYS, hold: 1'b0, target: STEP_IDLE};
         end
      endcase
      return w;
   endfunction

   // ceil(2^RECIP_SHIFT / (m+1)): exact floor division for 22-bit dividends
   function automatic logic [RECIP_W-1:0] recip(input logic [M_W-1:0] m);
      logic [RECIP_W-1:0] r;
      case (m)
         3'd1:    r = 25'd16777216;
         3'd2:    r = 25'd11184811;
         3'd3:    r = 25'd8388608;
         3'd4:    r = 25'd6710887;
         3'd5:    r = 25'd5592406;
         3'd6:    r = 25'd4793491;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[rtl/pmds_req_if.sv]
// Request channel of the PLL divider search: target frequency.
// Depends on pmds_pkg.
interface pmds_req_if;
   logic                        valid;
   logic                        ready;
   logic [pmds_pkg::TGT_W-1:0]  target_khz;

   modport source (output valid, output target_khz, input ready);
   modport sink (input valid, input target_khz, output ready);
endinterface

[rtl/pmds_rsp_if.sv]
// Response channel of the PLL divider search: chosen settings.
// Depends on pmds_pkg.
interface pmds_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pmds_pkg::N_W-1:0]     mult_n;
   logic [pmds_pkg::M_W-1:0]     div_m;
   logic [pmds_pkg::P_W-1:0]     post_p;
   logic [pmds_pkg::BAND_W-1:0]  vco_band;
   logic [pmds_pkg::FREQ_W-1:0]  actual_khz;
   logic                         found;

   modport source (output valid, output mult_n, output div_m, output post_p,
                   output vco_band, output actual_khz, output found, input ready);
   modport sink (input valid, input mult_n, input div_m, input post_p,
                 input vco_band, input actual_khz, input found, output ready);
endinterface

[rtl/pll_mnp_divider_search.sv]
// PLL M/N/P divider search, top level.
// Depends on pmds_pkg, pmds_req_if, pmds_rsp_if and the defines header.
//
// Usage: a request on req_chan carries a target frequency in kHz. The block
// walks post dividers 1, 2, 4, 8 and for each allowed one tries every N from
// N_TOP down to 7 and M from 1 to 6, one candidate per cycle, keeping the
// first candidate with the smallest error below 250000 kHz. One response on
// rsp_chan follows each request: N, M, P, VCO band, actual frequency, found.
// The next request is taken the cycle after the response loads. The candidate
// loop is set by the single shared reciprocal multiplier, which takes one
// candidate per cycle through a three-stage pipe.
// The response sits in an output register; a new request is taken while it
// waits, but the search result is only loaded once the old response has
// been taken, so a stalled receiver holds the block at its last step.
// The user writes ref_select and vco_max_code over the csr_ APB port, only
// while idle; the block does not enforce it. Reset (synchronous) returns to
// idle, drops the response and restores ref_select=1, vco_max_code=130.
module pll_mnp_divider_search #(
   parameter int N_TOP = 127
) (
   input  logic                          clock,
   input  logic                          reset,
   pmds_req_if.sink                      req_chan,
   pmds_rsp_if.source                    rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pmds_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [pmds_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [pmds_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import pmds_pkg::*;
`include "pll_mnp_divider_search_defines.svh"

   localparam logic [7:0] NTOP_P1 = 8'(N_TOP + 1);

   ucode_type             uc;
   logic                  cond_true, req_fire, out_free, post_skip, last_cand;
   logic                  csr_wr;
   logic [CSR_AW-3:0]     csr_idx;
   logic [REF_W-1:0]      ref_khz;
   logic [FVCO_W-1:0]     fvco;
   logic [VMAX_W-1:0]     vmax;
   logic [BAND_W-1:0]     band;
   logic [MUL_W-1:0]      mul_full;
   logic [FREQ_W-1:0]     cand_f;
   logic [ERR_W-1:0]      cand_d;

   logic [STEP_W-1:0]  pc_ff, pc_in;
   logic [TGT_W-1:0]   tgt_ff, tgt_in;
   logic [PIDX_W-1:0]  pidx_ff, pidx_in;
   logic [BAND_W-1:0]  band_ff, band_in;
   logic [N_W-1:0]     n_ff, n_in;
   logic [M_W-1:0]     m_ff, m_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   logic               a_valid_ff, a_valid_in;
   logic [PROD_W-1:0]  a_prod_ff, a_prod_in;
   logic [N_W-1:0]     a_n_ff, a_n_in;
   logic [M_W-1:0]     a_m_ff, a_m_in;
   logic [PIDX_W-1:0]  a_pidx_ff, a_pidx_in;
   logic [BAND_W-1:0]  a_band_ff, a_band_in;

   logic               b_valid_ff, b_valid_in;
   logic [PROD_W-1:0]  b_q_ff, b_q_in;
   logic [N_W-1:0]     b_n_ff, b_n_in;
   logic [M_W-1:0]     b_m_ff, b_m_in;
   logic [PIDX_W-1:0]  b_pidx_ff, b_pidx_in;
   logic [BAND_W-1:0]  b_band_ff, b_band_in;

   logic [ERR_W-1:0]   best_err_ff, best_err_in;
   logic [N_W-1:0]     best_n_ff, best_n_in;
   logic [M_W-1:0]     best_m_ff, best_m_in;
   logic [P_W-1:0]     best_p_ff, best_p_in;
   logic [BAND_W-1:0]  best_band_ff, best_band_in;
   logic [FREQ_W-1:0]  best_act_ff, best_act_in;
   logic               hit_ff, hit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [N_W-1:0]     rsp_n_ff, rsp_n_in;
   logic [M_W-1:0]     rsp_m_ff, rsp_m_in;
   logic [P_W-1:0]     rsp_p_ff, rsp_p_in;
   logic [BAND_W-1:0]  rsp_band_ff, rsp_band_in;
   logic [FREQ_W-1:0]  rsp_act_ff, rsp_act_in;
   logic               rsp_found_ff, rsp_found_in;

   logic               ref_sel_ff, ref_sel_in;
   logic [7:0]         vco_ff, vco_in;

   assign uc        = ucode_rom(pc_ff);
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign last_cand = (n_ff == N_MIN) && (m_ff == M_MAX);
   assign ref_khz   = ref_sel_ff ? REF_A_KHZ : REF_B_KHZ;
   assign fvco      = FVCO_W'(tgt_ff) << pidx_ff;
   assign vmax      = (VMAX_W'(vco_ff) + VCO_OFS) * VCO_SCALE;
   assign post_skip = (fvco < VCO_FLOOR) ||
                      ((pidx_ff != '0) && (fvco > FVCO_W'(vmax)));
   assign band      = BAND_W'(fvco > BAND_T1) + BAND_W'(fvco > BAND_T2)
                    + BAND_W'(fvco > BAND_T3);
   assign mul_full  = MUL_W'(a_prod_ff) * MUL_W'(recip(a_m_ff));
   assign cand_f    = FREQ_W'(b_q_ff >> b_pidx_ff);
   assign cand_d    = (cand_f >= FREQ_W'(tgt_ff)) ? cand_f - FREQ_W'(tgt_ff)
                                                   : FREQ_W'(tgt_ff) - cand_f;

   assign req_chan.ready = (uc.op == OP_ACCEPT);

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_idx)
         REG_REF_SELECT: csr_prdata = CSR_DW'(ref_sel_ff);
         REG_VCO_MAX:    csr_prdata = CSR_DW'(vco_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_comb begin
      case (uc.cond)
         C_REQ:       cond_true = req_fire;
         C_SKIP:      cond_true = post_skip;
         C_LAST:      cond_true = last_cand;
         C_MORE_POST: cond_true = (pidx_ff != PIDX_LAST);
         C_EMPTY:     cond_true = !a_valid_ff && !b_valid_ff;
         C_OUT_FREE:  cond_true = out_free;
         C_ALWAYS:    cond_true = 1'b1;
         default:     cond_true = 1'b0;
      endcase
   end

   always_comb begin
      pc_in   = cond_true ? uc.target : (uc.hold ? pc_ff : pc_ff + 1'b1);
      tgt_in  = tgt_ff;
      pidx_in = pidx_ff;
      band_in = band_ff;
      n_in    = n_ff;
      m_in    = m_ff;
      prod_in = prod_ff;

      a_valid_in = 1'b0;
      a_prod_in  = prod_ff;
      a_n_in     = n_ff;
      a_m_in     = m_ff;
      a_pidx_in  = pidx_ff;
      a_band_in  = band_ff;

      b_valid_in = a_valid_ff;
      b_q_in     = mul_full[RECIP_SHIFT +: PROD_W];
      b_n_in     = a_n_ff;
      b_m_in     = a_m_ff;
      b_pidx_in  = a_pidx_ff;
      b_band_in  = a_band_ff;

      best_err_in  = best_err_ff;
      best_n_in    = best_n_ff;
      best_m_in    = best_m_ff;
      best_p_in    = best_p_ff;
      best_band_in = best_band_ff;
      best_act_in  = best_act_ff;
      hit_in       = hit_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_n_in     = rsp_n_ff;
      rsp_m_in     = rsp_m_ff;
      rsp_p_in     = rsp_p_ff;
      rsp_band_in  = rsp_band_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_found_in = rsp_found_ff;

      ref_sel_in = ref_sel_ff;
      vco_in     = vco_ff;

      if (b_valid_ff && (cand_d < best_err_ff)) begin
         best_err_in  = cand_d;
         best_n_in    = b_n_ff;
         best_m_in    = b_m_ff;
         best_p_in    = P_W'((4'd1 << b_pidx_ff) - 4'd1);
         best_band_in = b_band_ff;
         best_act_in  = cand_f;
         hit_in       = 1'b1;
      end

      case (uc.op)
         OP_ACCEPT: begin
            if (req_fire) begin
               tgt_in       = req_chan.target_khz;
               pidx_in      = '0;
               best_err_in  = ERR_LIMIT;
               best_n_in    = '0;
               best_m_in    = '0;
               best_p_in    = '0;
               best_band_in = '0;
               best_act_in  = '0;
               hit_in       = 1'b0;
            end
         end
         OP_POST: begin
            band_in = band;
            n_in    = N_W'(N_TOP);
            m_in    = M_MIN;
            prod_in = PROD_W'(ref_khz) * PROD_W'(NTOP_P1);
         end
         OP_ISSUE: begin
            a_valid_in = 1'b1;
            if (m_ff == M_MAX) begin
               m_in    = M_MIN;
               n_in    = n_ff - 1'b1;
               prod_in = prod_ff - PROD_W'(ref_khz);
            end else begin
               m_in = m_ff + 1'b1;
            end
         end
         OP_NEXT: begin
            pidx_in = pidx_ff + 1'b1;
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_n_in     = best_n_ff;
               rsp_m_in     = best_m_ff;
               rsp_p_in     = best_p_ff;
               rsp_band_in  = best_band_ff;
               rsp_act_in   = best_act_ff;
               rsp_found_in = hit_ff;
            end
         end
         default: begin
         end
      endcase

      if (csr_wr) begin
         case (csr_idx)
            REG_REF_SELECT: ref_sel_in = csr_pwdata[0];
            REG_VCO_MAX:    vco_in     = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ref_sel_ff   <= REF_SEL_RST;
         vco_ff       <= VCO_MAX_RST;
      end else begin
         pc_ff        <= pc_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ref_sel_ff   <= ref_sel_in;
         vco_ff       <= vco_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff       <= tgt_in;
      pidx_ff      <= pidx_in;
      band_ff      <= band_in;
      n_ff         <= n_in;
      m_ff         <= m_in;
      prod_ff      <= prod_in;
      a_prod_ff    <= a_prod_in;
      a_n_ff       <= a_n_in;
      a_m_ff       <= a_m_in;
      a_pidx_ff    <= a_pidx_in;
      a_band_ff    <= a_band_in;
      b_q_ff       <= b_q_in;
      b_n_ff       <= b_n_in;
      b_m_ff       <= b_m_in;
      b_pidx_ff    <= b_pidx_in;
      b_band_ff    <= b_band_in;
      best_err_ff  <= best_err_in;
      best_n_ff    <= best_n_in;
      best_m_ff    <= best_m_in;
      best_p_ff    <= best_p_in;
      best_band_ff <= best_band_in;
      best_act_ff  <= best_act_in;
      hit_ff       <= hit_in;
      rsp_n_ff     <= rsp_n_in;
      rsp_m_ff     <= rsp_m_in;
      rsp_p_ff     <= rsp_p_in;
      rsp_band_ff  <= rsp_band_in;
      rsp_act_ff   <= rsp_act_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.mult_n     = rsp_n_ff;
   assign rsp_chan.div_m      = rsp_m_ff;
   assign rsp_chan.post_p     = rsp_p_ff;
   assign rsp_chan.vco_band   = rsp_band_ff;
   assign rsp_chan.actual_khz = rsp_act_ff;
   assign rsp_chan.found      = rsp_found_ff;

   `PMDS_ASSERT_IMPLY(a_issue_step, clock, reset, a_valid_ff,
      $past(pc_ff) == STEP_ISSUE)
   `PMDS_ASSERT_IMPLY(a_req_empty, clock, reset, req_fire, !a_valid_ff && !b_valid_ff)
   `PMDS_ASSERT_IMPLY(a_found_fields, clock, reset, rsp_valid_ff && rsp_found_ff,
      rsp_n_ff >= N_MIN && rsp_m_ff >= M_MIN && rsp_m_ff <= M_MAX)
   `PMDS_ASSERT_NEXT(a_emit_load, clock, reset, pc_ff == STEP_EMIT && out_free,
      rsp_valid_ff && pc_ff == STEP_IDLE)

endmodule

[bench/pll_mnp_divider_search_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the PLL M/N/P divider search: random and corner targets
// against an exhaustive in-bench search. Needs pmds_pkg, pmds_req_if, pmds_rsp_if
// and pll_mnp_divider_search.
module pll_mnp_divider_search_tb;
   import pmds_pkg::*;

   localparam int N_TOP       = 127;
   localparam int WATCH_LIMIT = 40000;
   localparam int SQUEEZE_CYC = 9000;
   localparam int CORNER_CNT  = 24;
   localparam int unsigned CORNER_TARGETS [CORNER_CNT] = '{
      0, 1, 3000, 6249, 6250, 12500, 25000, 28750, 28751, 49999, 50000, 50001,
      57500, 57501, 70000, 70001, 90000, 90001, 115000, 115001, 349525, 699050,
      524288, 1048575};

   typedef struct packed {
      logic [N_W-1:0]    mult_n;
      logic [M_W-1:0]    div_m;
      logic [P_W-1:0]    post_p;
      logic [BAND_W-1:0] vco_band;
      logic [FREQ_W-1:0] actual_khz;
      logic              found;
   } pll_setting_type;

   typedef struct {
      logic [TGT_W-1:0] target_khz;
      pll_setting_type  setting;
   } search_case_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   pmds_req_if req_bus ();
   pmds_rsp_if rsp_bus ();

   pll_mnp_divider_search #(.N_TOP(N_TOP)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [TGT_W-1:0] target_queue [$];
   search_case_type  expected_settings [$];
   search_case_type  head;
   pll_setting_type  got;

   logic       cfg_ref_sel  = REF_SEL_RST;
   logic [7:0] cfg_vco_code = VCO_MAX_RST;
   bit req_idle = 0;
   bit rsp_idle = 0;
   bit hold_request = 0;
   bit req_taken = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_wait = 0;
   int unsigned hold_left = 0;
   int unsigned watch_count = 0;
   int unsigned targets_queued = 0;
   int unsigned targets_sent = 0;
   int unsigned settings_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned not_found_count = 0;
   int unsigned setting_count = 0;
   int unsigned squeeze_count = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // exhaustive search over P, N, M; first strictly better candidate wins
   function automatic pll_setting_type search_dividers(input logic [TGT_W-1:0] tgt,
                                                       input logic ref_sel,
                                                       input logic [7:0] code);
      pll_setting_type best_set;
      int unsigned refk, vmax, best_err, post, fvco, f, d, n, m, pidx;
      best_set = '0;
      refk = 32'(ref_sel ? REF_A_KHZ : REF_B_KHZ);
      vmax = (int'(code) + 100) * 1000;
      best_err = 32'(ERR_LIMIT);
      for (pidx = 0; pidx < 4; pidx++) begin
         post = 1 << pidx;
         fvco = tgt * post;
         if (fvco < VCO_FLOOR || (post != 1 && fvco > vmax)) continue;
         for (n = N_TOP; n >= 7; n--) begin
            for (m = 1; m <= 6; m++) begin
               f = ((refk * (n + 1)) / (m + 1)) / post;
               d = (f >= tgt) ? f - tgt : tgt - f;
               if (d < best_err) begin
                  best_err = d;
                  best_set.mult_n = n[N_W-1:0];
                  best_set.div_m = m[M_W-1:0];
                  best_set.post_p = P_W'(post - 1);
                  best_set.vco_band = BAND_W'(fvco > BAND_T1) + BAND_W'(fvco > BAND_T2)
                                    + BAND_W'(fvco > BAND_T3);
                  best_set.actual_khz = f[FREQ_W-1:0];
                  best_set.found = 1'b1;
               end
            end
         end
      end
      return best_set;
   endfunction

   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   task automatic csr_write(input logic [CSR_AW-3:0] idx, input logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_REF_SELECT) cfg_ref_sel = value[0];
      else cfg_vco_code = value[7:0];
   endtask

   task automatic run_phase(input logic ref_sel, input logic [7:0] code, input int n_random,
                            input bit with_corners, input bit req_gaps, input bit rsp_gaps,
                            input bit squeeze);
      int unsigned t;
      int k;
      csr_write(REG_REF_SELECT, {31'd0, ref_sel});
      csr_write(REG_VCO_MAX, {24'd0, code});
      setting_count++;
      req_idle = req_gaps;
      rsp_idle = rsp_gaps;
      if (with_corners) begin
         for (k = 0; k < CORNER_CNT; k++) begin
            target_queue.push_back(CORNER_TARGETS[k][TGT_W-1:0]);
            targets_queued++;
         end
      end
      for (k = 0; k < n_random; k++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: t = $urandom_range(0, 60000);
            3, 4, 5, 6: t = $urandom_range(6250, 400000);
            // land on the VCO ceiling of a post divider
            7: t = (((int'(code) + 100) * 1000) >> $urandom_range(1, 3))
                   + $urandom_range(0, 2) - 1;
            default: t = $urandom_range(0, 20'hFFFFF);
         endcase
         target_queue.push_back(t[TGT_W-1:0]);
         targets_queued++;
      end
      if (squeeze) begin
         hold_request = 1;
         squeeze_count++;
      end
      do @(negedge clock);
      while (targets_sent != targets_queued || settings_checked != targets_sent);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.target_khz <= '0;
      end else if (!req_bus.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (target_queue.size() > 0) begin
            req_bus.target_khz <= target_queue.pop_front();
            req_bus.valid <= 1'b1;
            req_gap = req_idle ? idle_gap() : 0;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_left = SQUEEZE_CYC;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            rsp_wait = rsp_idle ? idle_gap() : 0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            head.target_khz = req_bus.target_khz;
            head.setting = search_dividers(req_bus.target_khz, cfg_ref_sel, cfg_vco_code);
            expected_settings.push_back(head);
            targets_sent++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.mult_n = rsp_bus.mult_n;
            got.div_m = rsp_bus.div_m;
            got.post_p = rsp_bus.post_p;
            got.vco_band = rsp_bus.vco_band;
            got.actual_khz = rsp_bus.actual_khz;
            got.found = rsp_bus.found;
            if (expected_settings.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("tb: unexpected response N=%0d M=%0d P=%0d band=%0d f=%0d found=%0d",
                           got.mult_n, got.div_m, got.post_p, got.vco_band, got.actual_khz,
                           got.found);
            end else begin
               head = expected_settings.pop_front();
               settings_checked++;
               if (!head.setting.found) not_found_count++;
               if (got !== head.setting) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"tb: mismatch target=%0d exp N=%0d M=%0d P=%0d band=%0d f=%0d ",
                               "found=%0d got N=%0d M=%0d P=%0d band=%0d f=%0d found=%0d"},
                              head.target_khz, head.setting.mult_n, head.setting.div_m,
                              head.setting.post_p, head.setting.vco_band,
                              head.setting.actual_khz, head.setting.found, got.mult_n,
                              got.div_m, got.post_p, got.vco_band, got.actual_khz, got.found);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            watch_count <= 0;
         else
            watch_count <= watch_count + 1;
         if (watch_count == WATCH_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.target_khz = '0;
      rsp_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      run_phase(REF_SEL_RST, VCO_MAX_RST, 40, 1, 0, 0, 0);
      run_phase(1'b0, 8'd0, 40, 0, 1, 1, 0);
      run_phase(1'b1, 8'd255, 40, 0, 1, 1, 1);
      run_phase(1'b0, VCO_MAX_RST, 40, 0, 0, 1, 0);
      run_phase(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 40, 0, 1, 1, 0);

      repeat (100) @(negedge clock);
      $display("tb: %0d targets searched under %0d reference/VCO-ceiling settings",
               targets_sent, setting_count);
      $display("tb: %0d with no usable divider, %0d long receiver hold-offs, %0d mismatches",
               not_found_count, squeeze_count, mismatch_count);
      if (mismatch_count == 0 && expected_settings.size() == 0 &&
          settings_checked == targets_sent)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
